// File: rtl/core/crc8df_pkg.sv
// Shared types, constants and the CRC-8 step function of the packet deframer.
`default_nettype none

package crc8df_pkg;

  // One received link byte with its start-of-transfer flag.
  typedef struct packed {
    logic [7:0] rx_byte;
    logic       first_of_transfer;
  } in_t;

  // One result of a validated frame.
  typedef struct packed {
    logic [7:0] payload_byte;
    logic [5:0] payload_length;
    logic       empty_frame;
    logic       is_last;
  } out_t;

  // Descriptor of a good frame: the store bank that holds it and its length.
  typedef struct packed {
    logic       bank;
    logic [7:0] len;
  } desc_t;

  // A bank handed back by the burst side once its last byte has been read.
  typedef struct packed {
    logic valid;
    logic bank;
  } bank_rel_t;

  localparam logic [7:0] MAGIC_FIRST  = 8'hCA;
  localparam logic [7:0] MAGIC_SECOND = 8'hFE;
  localparam logic [7:0] CRC_POLY     = 8'h07;

  typedef enum logic [3:0] {
    PH_IDLE    = 4'b0001,
    PH_HEADER  = 4'b0010,
    PH_PAYLOAD = 4'b0100,
    PH_CRC     = 4'b1000
  } phase_t;

  typedef enum logic [1:0] {
    HDR_MAGIC0 = 2'd0,
    HDR_MAGIC1 = 2'd1,
    HDR_LENGTH = 2'd2
  } hdr_pos_t;

  // One byte of CRC-8, polynomial 0x07, MSB first.
  function automatic logic [7:0] crc8_update(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int k = 0; k < 8; k++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// File: rtl/core/crc8df_store.sv
// Two-bank payload store: one write port, one registered read port.
`default_nettype none

module crc8df_store #(
  parameter int MAX_PAYLOAD = 61
) (
  input  wire logic                                          clk,
  input  wire logic                                          wr_en,
  input  wire logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1):0] wr_addr,
  input  wire logic [7:0]                                    wr_data,
  input  wire logic                                          rd_en,
  input  wire logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1):0] rd_addr,
  output logic [7:0]                                         rd_data
);

  localparam int AW    = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int DEPTH = 2 ** (AW + 1);

  logic [7:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/crc8df_queue.sv
// Two-entry descriptor queue between the frame parser and the burst engine.
`default_nettype none

module crc8df_queue (
  input  wire logic               clk,
  input  wire logic               rst_n,
  input  wire logic               push,
  input  wire crc8df_pkg::desc_t  push_desc,
  output logic                    full,
  input  wire logic               pop,
  output crc8df_pkg::desc_t       pop_desc,
  output logic                    empty
);

  import crc8df_pkg::*;

  desc_t      ent_r [2];
  logic       wp_r, wp_nxt;
  logic       rp_r, rp_nxt;
  logic [1:0] cnt_r, cnt_nxt;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_desc = ent_r[rp_r];

  always_comb begin
    wp_nxt  = wp_r;
    rp_nxt  = rp_r;
    cnt_nxt = cnt_r;
    if (push && !full) begin
      wp_nxt = ~wp_r;
    end
    if (pop && !empty) begin
      rp_nxt = ~rp_r;
    end
    if ((push && !full) && !(pop && !empty)) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (!(push && !full) && (pop && !empty)) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push && !full) begin
      ent_r[wp_r] <= push_desc;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/crc8df_front.sv
// Frame parser: checks magic and length, stores the payload, checks the CRC.
`default_nettype none

module crc8df_front #(
  parameter int MAX_PAYLOAD = 61
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire logic                                          in_push,
  input  wire crc8df_pkg::in_t                               in_data,
  output logic                                               in_full,
  output logic                                               q_push,
  output crc8df_pkg::desc_t                                  q_desc,
  input  wire logic                                          q_full,
  input  wire crc8df_pkg::bank_rel_t                         bank_rel,
  output logic                                               mem_we,
  output logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1):0] mem_waddr,
  output logic [7:0]                                         mem_wdata
);

  import crc8df_pkg::*;

  localparam int         AW      = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam logic [7:0] MAX_LEN = 8'(MAX_PAYLOAD);

  phase_t     phase_r, phase_nxt;
  hdr_pos_t   hpos_r, hpos_nxt;
  logic [7:0] pos_r, pos_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] crc_r, crc_nxt;
  logic       wbank_r, wbank_nxt;
  logic [1:0] busy_r, busy_nxt;

  phase_t     eff_phase;
  hdr_pos_t   eff_hpos;
  logic [7:0] eff_crc;
  logic [7:0] pos_inc;
  logic [1:0] busy_set;
  logic [1:0] busy_clr;
  logic       accept;
  logic [7:0] b;

  // Hold off while the payload would land in a bank still being drained,
  // or while a CRC byte could find the descriptor queue full.
  assign in_full = ((phase_r == PH_PAYLOAD) && busy_r[wbank_r]) ||
                   ((phase_r == PH_CRC) && q_full);
  assign accept  = in_push && !in_full;
  assign b       = in_data.rx_byte;
  assign pos_inc = pos_r + 8'd1;

  assign mem_waddr = {wbank_r, pos_r[AW-1:0]};
  assign mem_wdata = b;
  assign q_desc    = '{bank: wbank_r, len: len_r};
  assign busy_clr  = bank_rel.valid ? 2'(2'b01 << bank_rel.bank) : 2'b00;

  always_comb begin
    phase_nxt = phase_r;
    hpos_nxt  = hpos_r;
    pos_nxt   = pos_r;
    len_nxt   = len_r;
    crc_nxt   = crc_r;
    wbank_nxt = wbank_r;
    busy_set  = 2'b00;
    mem_we    = 1'b0;
    q_push    = 1'b0;

    eff_phase = in_data.first_of_transfer ? PH_HEADER : phase_r;
    eff_hpos  = in_data.first_of_transfer ? HDR_MAGIC0 : hpos_r;
    eff_crc   = in_data.first_of_transfer ? 8'd0 : crc_r;

    if (accept) begin
      if (in_data.first_of_transfer) begin
        phase_nxt = PH_HEADER;
        hpos_nxt  = HDR_MAGIC0;
        pos_nxt   = 8'd0;
        len_nxt   = 8'd0;
        crc_nxt   = 8'd0;
      end
      case (eff_phase)
        PH_HEADER: begin
          case (eff_hpos)
            HDR_MAGIC0: begin
              if (b == MAGIC_FIRST) hpos_nxt = HDR_MAGIC1;
              else phase_nxt = PH_IDLE;
            end
            HDR_MAGIC1: begin
              if (b == MAGIC_SECOND) hpos_nxt = HDR_LENGTH;
              else phase_nxt = PH_IDLE;
            end
            default: begin
              if (b > MAX_LEN) begin
                phase_nxt = PH_IDLE;
              end else begin
                len_nxt   = b;
                pos_nxt   = 8'd0;
                crc_nxt   = 8'd0;
                phase_nxt = (b == 8'd0) ? PH_CRC : PH_PAYLOAD;
              end
            end
          endcase
        end
        PH_PAYLOAD: begin
          mem_we  = 1'b1;
          crc_nxt = crc8_update(eff_crc, b);
          pos_nxt = pos_inc;
          if (pos_inc >= len_r) phase_nxt = PH_CRC;
        end
        PH_CRC: begin
          if (b == eff_crc) begin
            q_push = 1'b1;
            // A frame with payload hands its bank to the burst side.
            if (len_r != 8'd0) begin
              busy_set  = 2'(2'b01 << wbank_r);
              wbank_nxt = ~wbank_r;
            end
          end
          phase_nxt = PH_IDLE;
        end
        default: begin
        end
      endcase
    end

    busy_nxt = (busy_r & ~busy_clr) | busy_set;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_IDLE;
      hpos_r  <= HDR_MAGIC0;
      pos_r   <= 8'd0;
      len_r   <= 8'd0;
      crc_r   <= 8'd0;
      wbank_r <= 1'b0;
      busy_r  <= 2'b00;
    end else begin
      phase_r <= phase_nxt;
      hpos_r  <= hpos_nxt;
      pos_r   <= pos_nxt;
      len_r   <= len_nxt;
      crc_r   <= crc_nxt;
      wbank_r <= wbank_nxt;
      busy_r  <= busy_nxt;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/crc8df_back.sv
// Burst engine: reads a good frame's payload out of the store into a result queue.
`default_nettype none

module crc8df_back #(
  parameter int MAX_PAYLOAD = 61
) (
  input  wire logic                                          clk,
  input  wire logic                                          rst_n,
  input  wire crc8df_pkg::desc_t                             q_desc,
  input  wire logic                                          q_empty,
  output logic                                               q_pop,
  output crc8df_pkg::bank_rel_t                              bank_rel,
  output logic                                               mem_re,
  output logic [((MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1):0] mem_raddr,
  input  wire logic [7:0]                                    mem_rdata,
  input  wire logic                                          out_pop,
  output logic                                               out_empty,
  output crc8df_pkg::out_t                                   out_data
);

  import crc8df_pkg::*;

  localparam int AW     = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;
  localparam int ODEPTH = 4;

  logic       act_r, act_nxt;
  logic       bank_r, bank_nxt;
  logic [7:0] len_r, len_nxt;
  logic [7:0] idx_r, idx_nxt;

  logic       rd_v_r, rd_v_nxt;
  logic [5:0] rd_len_r, rd_len_nxt;
  logic       rd_last_r, rd_last_nxt;
  logic       rd_mark_r, rd_mark_nxt;

  out_t       ofifo_r [ODEPTH];
  logic [1:0] owp_r, owp_nxt;
  logic [1:0] orp_r, orp_nxt;
  logic [2:0] ocnt_r, ocnt_nxt;

  logic       credit;
  logic       issue;
  logic       last;
  logic       opush;
  logic       opop;
  out_t       oentry;

  // Reads in flight plus queued results never exceed the result queue depth.
  assign credit = ({1'b0, ocnt_r} + {3'b000, rd_v_r}) < 4'(ODEPTH);
  assign issue  = act_r && credit;
  assign last   = (len_r == 8'd0) || ((idx_r + 8'd1) == len_r);
  assign q_pop  = !act_r && !q_empty;

  assign mem_re    = issue && (len_r != 8'd0);
  assign mem_raddr = {bank_r, idx_r[AW-1:0]};
  assign bank_rel  = '{valid: issue && last && (len_r != 8'd0), bank: bank_r};

  assign opush     = rd_v_r;
  assign opop      = out_pop && !out_empty;
  assign out_empty = (ocnt_r == 3'd0);
  assign out_data  = ofifo_r[orp_r];

  assign oentry = '{payload_byte:   rd_mark_r ? 8'd0 : mem_rdata,
                    payload_length: rd_len_r,
                    empty_frame:    rd_mark_r,
                    is_last:        rd_last_r};

  always_comb begin
    act_nxt     = act_r;
    bank_nxt    = bank_r;
    len_nxt     = len_r;
    idx_nxt     = idx_r;
    rd_v_nxt    = issue;
    rd_len_nxt  = len_r[5:0];
    rd_last_nxt = last;
    rd_mark_nxt = (len_r == 8'd0);

    if (q_pop) begin
      act_nxt  = 1'b1;
      bank_nxt = q_desc.bank;
      len_nxt  = q_desc.len;
      idx_nxt  = 8'd0;
    end else if (issue) begin
      idx_nxt = idx_r + 8'd1;
      if (last) act_nxt = 1'b0;
    end

    owp_nxt  = opush ? owp_r + 2'd1 : owp_r;
    orp_nxt  = opop ? orp_r + 2'd1 : orp_r;
    ocnt_nxt = ocnt_r;
    if (opush && !opop) ocnt_nxt = ocnt_r + 3'd1;
    else if (!opush && opop) ocnt_nxt = ocnt_r - 3'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      act_r  <= 1'b0;
      rd_v_r <= 1'b0;
      owp_r  <= 2'd0;
      orp_r  <= 2'd0;
      ocnt_r <= 3'd0;
    end else begin
      act_r  <= act_nxt;
      rd_v_r <= rd_v_nxt;
      owp_r  <= owp_nxt;
      orp_r  <= orp_nxt;
      ocnt_r <= ocnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    bank_r    <= bank_nxt;
    len_r     <= len_nxt;
    idx_r     <= idx_nxt;
    rd_len_r  <= rd_len_nxt;
    rd_last_r <= rd_last_nxt;
    rd_mark_r <= rd_mark_nxt;
    if (opush) begin
      ofifo_r[owp_r] <= oentry;
    end
  end

  a_ofifo_bound: assert property (@(posedge clk) disable iff (!rst_n)
    ocnt_r <= 3'(ODEPTH))
    else $error("result queue overflow");

  a_push_has_room: assert property (@(posedge clk) disable iff (!rst_n)
    opush |-> (ocnt_r < 3'(ODEPTH)) || opop)
    else $error("result written into a full queue");

  a_last_ends_burst: assert property (@(posedge clk) disable iff (!rst_n)
    issue && last |=> !act_r && rd_v_r && rd_last_r)
    else $error("burst did not end after its last read");

  a_rel_only_payload: assert property (@(posedge clk) disable iff (!rst_n)
    bank_rel.valid |-> mem_re)
    else $error("bank released without a final payload read");

endmodule

`default_nettype wire

// File: rtl/core/crc8_packet_deframer.sv
// Top level of the CRC-8 framed packet deframer: parser, descriptor queue, store, burst engine.
// Input: one byte per cycle; full rises only when a payload byte would enter a bank
//   whose previous frame is still being read out, or a CRC byte meets a full queue.
// Output: a good frame's burst gives one result per cycle while pop is held; the first
//   result goes through the descriptor queue, burst engine, store read and result queue.
// Reset (rst_n low, synchronous) clears all control state; the payload store is not cleared.
`default_nettype none

module crc8_packet_deframer #(
  parameter int MAX_PAYLOAD = 61
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire logic             in_push,
  input  wire crc8df_pkg::in_t  in_data,
  output logic                  in_full,
  input  wire logic             out_pop,
  output logic                  out_empty,
  output crc8df_pkg::out_t      out_data
);

  import crc8df_pkg::*;

  localparam int AW = (MAX_PAYLOAD > 1) ? $clog2(MAX_PAYLOAD) : 1;

  // The parser writes each payload byte into one of two store banks as it arrives
  // and checks the running CRC. A good frame leaves a descriptor in the queue and,
  // if it has payload, the parser moves on to the other bank, so the next frame's
  // header and payload can arrive while the previous burst is still draining.
  logic        q_push;
  desc_t       q_push_desc;
  logic        q_full;
  logic        q_pop;
  desc_t       q_pop_desc;
  logic        q_empty;
  bank_rel_t   bank_rel;

  logic        mem_we;
  logic [AW:0] mem_waddr;
  logic [7:0]  mem_wdata;
  logic        mem_re;
  logic [AW:0] mem_raddr;
  logic [7:0]  mem_rdata;

  crc8df_front #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_push   (in_push),
    .in_data   (in_data),
    .in_full   (in_full),
    .q_push    (q_push),
    .q_desc    (q_push_desc),
    .q_full    (q_full),
    .bank_rel  (bank_rel),
    .mem_we    (mem_we),
    .mem_waddr (mem_waddr),
    .mem_wdata (mem_wdata)
  );

  crc8df_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_desc (q_push_desc),
    .full      (q_full),
    .pop       (q_pop),
    .pop_desc  (q_pop_desc),
    .empty     (q_empty)
  );

  crc8df_store #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_store (
    .clk     (clk),
    .wr_en   (mem_we),
    .wr_addr (mem_waddr),
    .wr_data (mem_wdata),
    .rd_en   (mem_re),
    .rd_addr (mem_raddr),
    .rd_data (mem_rdata)
  );

  // The burst engine takes one descriptor at a time, reads its bytes in order and
  // hands the bank back with the last read. An empty frame becomes a single marker.
  crc8df_back #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .q_desc    (q_pop_desc),
    .q_empty   (q_empty),
    .q_pop     (q_pop),
    .bank_rel  (bank_rel),
    .mem_re    (mem_re),
    .mem_raddr (mem_raddr),
    .mem_rdata (mem_rdata),
    .out_pop   (out_pop),
    .out_empty (out_empty),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

// File: dv/tb_crc8_packet_deframer.sv
// Self-checking testbench for the CRC-8 packet deframer: directed frames, then random traffic.
module tb_crc8_packet_deframer;
  import crc8df_pkg::*;

  // Largest payload that the block accepts. A length byte above this drops the frame.
  localparam int MAX_PAYLOAD = 61;

  // The random part is split into four idling phases of this many counted items each.
  localparam int unsigned PHASE_ITEMS = 55;

  // How long the receiver refuses results during the back-pressure stretch.
  localparam int unsigned HOLD_CYCLES = 300;

  // Cycles without any transfer before the run is declared hung. The longest correct
  // quiet stretch is the receiver hold above plus the pipeline latency.
  localparam int unsigned QUIET_LIMIT = 2000;

  // Cycles to keep watching the result side once nothing is expected any more.
  // A burst's first result passes the descriptor queue, burst engine and store read.
  localparam int unsigned DRAIN_CYCLES = 32;

  // Results that the directed table types in by hand.
  localparam out_t EMPTY_MARKER = '{8'h00, 6'd0, 1'b1, 1'b1};
  localparam out_t SINGLE_FF    = '{8'hFF, 6'd1, 1'b0, 1'b1};
  localparam out_t NO_RESULT    = '0;

  // How a directed row builds its byte: as written, or from the running CRC.
  typedef enum logic [1:0] {
    ROW_RAW,
    ROW_GOOD_CRC,
    ROW_BAD_CRC
  } row_kind_t;

  typedef struct packed {
    row_kind_t  kind;
    logic [7:0] rx_byte;
    logic       first;
    logic       typed;
    out_t       res;
  } dir_row_t;

  // Ways in which a random frame is broken, if at all.
  typedef enum logic [2:0] {
    FR_GOOD,
    FR_BAD_MAGIC0,
    FR_BAD_MAGIC1,
    FR_OVERSIZE,
    FR_BAD_CRC,
    FR_CUT
  } frame_fault_t;

  // Which side of the block idles in the current phase.
  typedef enum logic [1:0] {
    IDLE_NONE,
    IDLE_SENDER,
    IDLE_RECEIVER,
    IDLE_BOTH
  } idle_mode_t;

  logic clk;
  logic rst_n   = 1'b0;
  logic in_push = 1'b0;
  in_t  in_data = '0;
  logic in_full;
  logic out_pop = 1'b0;
  logic out_empty;
  out_t out_data;

  crc8_packet_deframer #(
    .MAX_PAYLOAD(MAX_PAYLOAD)
  ) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_push  (in_push),
    .in_data  (in_data),
    .in_full  (in_full),
    .out_pop  (out_pop),
    .out_empty(out_empty),
    .out_data (out_data)
  );

  // The directed table. Rows whose result is obvious carry it typed in; all other rows
  // are checked against the predictor. The CRC rows take their byte from the running CRC.
  dir_row_t directed_rows [25] = '{
    // A good empty frame gives one marker result.
    '{ROW_RAW,      8'hCA, 1'b1, 1'b0, NO_RESULT},
    '{ROW_RAW,      8'hFE, 1'b0, 1'b0, NO_RESULT},
    '{ROW_RAW,      8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_GOOD_CRC, 8'h00, 1'b0, 1'b1, EMPTY_MARKER},
    // A trailing byte after the CRC is ignored.
    '{ROW_RAW,      8'hFF, 1'b0, 1'b0, NO_RESULT},
    // Bad first magic byte.
    '{ROW_RAW,      8'h00, 1'b1, 1'b0, NO_RESULT},
    // Bad second magic byte.
    '{ROW_RAW,      8'hCA, 1'b1, 1'b0, NO_RESULT},
    '{ROW_RAW,      8'hFF, 1'b0, 1'b0, NO_RESULT},
    // Length one above the maximum.
    '{ROW_RAW,      8'hCA, 1'b1, 1'b0, NO_RESULT},
    '{ROW_RAW,      8'hFE, 1'b0, 1'b0, NO_RESULT},
    '{ROW_RAW,      8'h3E, 1'b0, 1'b0, NO_RESULT},
    // A frame cut short by a new start on its second payload byte; the new frame is good.
    '{ROW_RAW,      8'hCA, 1'b1, 1'b0, NO_RESULT},
    '{ROW_RAW,      8'hFE, 1'b0, 1'b0, NO_RESULT},
    '{ROW_RAW,      8'h02, 1'b0, 1'b0, NO_RESULT},
    '{ROW_RAW,      8'h11, 1'b0, 1'b0, NO_RESULT},
    '{ROW_RAW,      8'hCA, 1'b1, 1'b0, NO_RESULT},
    '{ROW_RAW,      8'hFE, 1'b0, 1'b0, NO_RESULT},
    '{ROW_RAW,      8'h01, 1'b0, 1'b0, NO_RESULT},
    '{ROW_RAW,      8'hFF, 1'b0, 1'b0, NO_RESULT},
    '{ROW_GOOD_CRC, 8'h00, 1'b0, 1'b1, SINGLE_FF},
    // CRC mismatch drops the frame.
    '{ROW_RAW,      8'hCA, 1'b1, 1'b0, NO_RESULT},
    '{ROW_RAW,      8'hFE, 1'b0, 1'b0, NO_RESULT},
    '{ROW_RAW,      8'h01, 1'b0, 1'b0, NO_RESULT},
    '{ROW_RAW,      8'h00, 1'b0, 1'b0, NO_RESULT},
    '{ROW_BAD_CRC,  8'h00, 1'b0, 1'b0, NO_RESULT}
  };

  // Predictor state: what the frame parser should hold after every accepted byte.
  phase_t     rx_phase = PH_IDLE;
  hdr_pos_t   rx_hdr   = HDR_MAGIC0;
  logic [6:0] rx_count = '0;
  logic [7:0] rx_len   = '0;
  logic [7:0] rx_crc   = '0;
  logic [7:0] rx_store [MAX_PAYLOAD];

  // Results still owed by the block, oldest first.
  out_t awaited_results [$];

  idle_mode_t  idle_mode     = IDLE_NONE;
  bit          hold_req      = 1'b0;
  int unsigned items_taken   = 0;
  int unsigned error_count   = 0;

  initial begin
    clk = 1'b0;
    forever #4 clk = ~clk;
  end

  // One byte of the link CRC: polynomial 0x07, MSB first.
  function automatic logic [7:0] crc_next(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    repeat (8) c = {c[6:0], 1'b0} ^ (c[7] ? CRC_POLY : 8'h00);
    return c;
  endfunction

  // Percentage of cycles in which a side idles during the current phase.
  function automatic int unsigned gap_pct(input bit receiver);
    case (idle_mode)
      IDLE_SENDER:   return receiver ? 0 : 60;
      IDLE_RECEIVER: return receiver ? 60 : 0;
      IDLE_BOTH:     return 16;
      default:       return 0;
    endcase
  endfunction

  // Advances the parser prediction by one accepted byte. When emit is set, the burst of a
  // good frame is queued as owed results; typed directed rows queue their own instead.
  task automatic deframe_byte(input in_t x, input bit emit);
    logic [7:0] b;
    b = x.rx_byte;
    // A start flag abandons whatever frame was in progress and begins a new header.
    if (x.first_of_transfer) begin
      rx_phase = PH_HEADER;
      rx_hdr   = HDR_MAGIC0;
      rx_count = '0;
      rx_len   = '0;
      rx_crc   = '0;
    end
    case (rx_phase)
      PH_HEADER: begin
        case (rx_hdr)
          HDR_MAGIC0: begin
            if (b == MAGIC_FIRST) rx_hdr = HDR_MAGIC1;
            else rx_phase = PH_IDLE;
          end
          HDR_MAGIC1: begin
            if (b == MAGIC_SECOND) rx_hdr = HDR_LENGTH;
            else rx_phase = PH_IDLE;
          end
          default: begin
            if (b > MAX_PAYLOAD) begin
              rx_phase = PH_IDLE;
            end else begin
              rx_len   = b;
              rx_count = '0;
              rx_crc   = '0;
              rx_phase = (b == 8'd0) ? PH_CRC : PH_PAYLOAD;
            end
          end
        endcase
      end
      PH_PAYLOAD: begin
        rx_store[rx_count[5:0]] = b;
        rx_crc   = crc_next(rx_crc, b);
        rx_count = rx_count + 7'd1;
        if (rx_count >= rx_len) rx_phase = PH_CRC;
      end
      PH_CRC: begin
        if (b == rx_crc && emit) begin
          if (rx_len == 8'd0) begin
            awaited_results.push_back(EMPTY_MARKER);
          end else begin
            for (int i = 0; i < rx_len; i++) begin
              awaited_results.push_back('{rx_store[i], rx_len[5:0], 1'b0, i + 1 == rx_len});
            end
          end
        end
        rx_phase = PH_IDLE;
      end
      default: ;
    endcase
  endtask

  // Offers one byte, with random gaps before it, and waits for its transfer. Bytes that the
  // parser ignores (no start flag while idle) do not count toward the item budget.
  task automatic push_byte(input in_t x, input bit typed = 1'b0, input out_t typed_res = '0);
    while ($urandom_range(0, 99) < gap_pct(1'b0)) begin
      in_push <= 1'b0;
      @(posedge clk);
    end
    in_push <= 1'b1;
    in_data <= x;
    do @(posedge clk); while (in_full);
    if (x.first_of_transfer || rx_phase != PH_IDLE) items_taken++;
    deframe_byte(x, !typed);
    if (typed) awaited_results.push_back(typed_res);
  endtask

  // Sends one frame with random payload, broken in the way that fault names.
  task automatic send_frame(input int unsigned len, input frame_fault_t fault);
    in_t         x;
    int unsigned cut;
    // A cut frame stops before payload byte cut, or before the CRC when cut equals len.
    cut = (fault == FR_CUT) ? $urandom_range(0, len) : len + 1;
    x = '{MAGIC_FIRST, 1'b1};
    if (fault == FR_BAD_MAGIC0) x.rx_byte ^= 8'($urandom_range(1, 255));
    push_byte(x);
    if (fault == FR_BAD_MAGIC0) return;
    x = '{MAGIC_SECOND, 1'b0};
    if (fault == FR_BAD_MAGIC1) x.rx_byte ^= 8'($urandom_range(1, 255));
    push_byte(x);
    if (fault == FR_BAD_MAGIC1) return;
    x = '{8'(len), 1'b0};
    if (fault == FR_OVERSIZE) x.rx_byte = 8'($urandom_range(MAX_PAYLOAD + 1, 255));
    push_byte(x);
    if (fault == FR_OVERSIZE) return;
    for (int unsigned i = 0; i < len; i++) begin
      if (i == cut) return;
      x = '{8'($urandom), 1'b0};
      push_byte(x);
    end
    if (cut == len) return;
    x = '{rx_crc, 1'b0};
    if (fault == FR_BAD_CRC) x.rx_byte ^= 8'($urandom_range(1, 255));
    push_byte(x);
  endtask

  // Link bytes outside any frame: mostly ignored, sometimes a stray start flag.
  task automatic send_noise(input int unsigned count, input bit allow_start);
    in_t x;
    repeat (count) begin
      x = '{8'($urandom), allow_start && ($urandom_range(0, 3) == 0)};
      push_byte(x);
    end
  endtask

  // One random traffic element. Well-formed frames dominate, so that bursts of every size
  // come out, while the rest exercises every way in which a frame is dropped.
  task automatic send_random_element();
    int unsigned pick;
    int unsigned size_pick;
    int unsigned len;
    pick      = $urandom_range(0, 99);
    size_pick = $urandom_range(0, 99);
    // Most frames are short; a few hit the maximum and some land in between.
    if (size_pick < 10) len = MAX_PAYLOAD;
    else if (size_pick < 20) len = $urandom_range(9, MAX_PAYLOAD - 1);
    else len = $urandom_range(0, 8);
    if (pick < 60) begin
      send_frame(len, FR_GOOD);
      if ($urandom_range(0, 3) == 0) send_noise($urandom_range(1, 3), 1'b0);
    end else if (pick < 68) begin
      send_frame(len, FR_BAD_CRC);
    end else if (pick < 75) begin
      send_frame((len == 0) ? 1 : len, FR_CUT);
    end else if (pick < 80) begin
      send_frame(len, FR_BAD_MAGIC0);
    end else if (pick < 85) begin
      send_frame(len, FR_BAD_MAGIC1);
    end else if (pick < 90) begin
      send_frame(len, FR_OVERSIZE);
    end else begin
      send_noise($urandom_range(1, 4), 1'b1);
    end
  endtask

  function automatic void check_field(input string name, input int unsigned expected,
                                      input int unsigned actual);
    if (expected != actual) begin
      $error("%s: expected %0h, got %0h", name, expected, actual);
      error_count++;
    end
  endfunction

  // Result side. Each transfer is compared with the oldest owed result, then the next pop
  // is chosen. A hold request from the stimulus makes the receiver refuse results for a long
  // stretch, so that both store banks fill and in_full rises.
  initial begin
    int unsigned hold_left;
    out_t        want;
    hold_left = 0;
    forever begin
      @(posedge clk);
      if (rst_n && out_pop && !out_empty) begin
        if (awaited_results.size() == 0) begin
          $error("unexpected result: payload_byte %0h payload_length %0d empty_frame %0b",
                 out_data.payload_byte, out_data.payload_length, out_data.empty_frame);
          error_count++;
        end else begin
          want = awaited_results.pop_front();
          check_field("payload_byte", want.payload_byte, out_data.payload_byte);
          check_field("payload_length", want.payload_length, out_data.payload_length);
          check_field("empty_frame", want.empty_frame, out_data.empty_frame);
          check_field("is_last", want.is_last, out_data.is_last);
        end
      end
      if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HOLD_CYCLES;
      end
      if (hold_left > 0) begin
        hold_left--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= rst_n && ($urandom_range(0, 99) >= gap_pct(1'b1));
      end
    end
  end

  // Watchdog: counts cycles in which neither side completes a transfer.
  initial begin
    int unsigned quiet;
    quiet = 0;
    forever begin
      @(posedge clk);
      if ((in_push && !in_full) || (out_pop && !out_empty)) quiet = 0;
      else quiet++;
      if (quiet >= QUIET_LIMIT) begin
        $display("DONE: errors detected");
        $finish;
      end
    end
  end

  // Stimulus: reset, the directed table, then the random phases.
  initial begin
    in_t x;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    foreach (directed_rows[i]) begin
      x.first_of_transfer = directed_rows[i].first;
      case (directed_rows[i].kind)
        ROW_GOOD_CRC: x.rx_byte = rx_crc;
        ROW_BAD_CRC:  x.rx_byte = ~rx_crc;
        default:      x.rx_byte = directed_rows[i].rx_byte;
      endcase
      push_byte(x, directed_rows[i].typed, directed_rows[i].res);
    end

    items_taken = 0;
    for (int m = 0; m < 4; m++) begin
      idle_mode = idle_mode_t'(m);
      // The back-pressure stretch opens the phase without idling: the receiver stops while
      // three short good frames go in, which is more than the two banks can hold.
      if (idle_mode == IDLE_NONE) begin
        hold_req = 1'b1;
        repeat (3) send_frame($urandom_range(4, 12), FR_GOOD);
      end
      while (items_taken < (m + 1) * PHASE_ITEMS) send_random_element();
    end
    in_push <= 1'b0;

    // Let the last bursts drain at full rate, then keep watching for stray results.
    idle_mode = IDLE_NONE;
    while (awaited_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (error_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
